/* src/crc_cfr_pkg.sv */
`timescale 1ns / 1ps

package crc_cfr_pkg;

    localparam int PAYLOAD_BYTES = 6;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [11:0] DUTY_MAX = 12'd4095;
    localparam int          DUTY_SHIFT = 10;

    localparam logic [2:0] POS_BITS   = 3'd1;
    localparam logic [2:0] POS_A_LO   = 3'd2;
    localparam logic [2:0] POS_A_HI   = 3'd3;
    localparam logic [2:0] POS_B_LO   = 3'd4;
    localparam logic [2:0] POS_B_HI   = 3'd5;
    localparam logic [2:0] POS_CRC_LO = 3'(PAYLOAD_BYTES);
    localparam logic [2:0] POS_CRC_HI = 3'(PAYLOAD_BYTES + 1);

    typedef struct packed {
        logic [11:0] duty_b;
        logic [11:0] duty_a;
        logic [2:0]  digital_out;
        logic        crc_ok;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [11:0] scale_duty(input logic [15:0] raw);
        logic [27:0] prod;
        logic [17:0] quot;
        prod = 28'(raw) * 28'(DUTY_MAX);
        quot = prod[27:DUTY_SHIFT];
        return (quot[17:12] != 6'd0) ? DUTY_MAX : quot[11:0];
    endfunction

endpackage

/* src/crc16_command_frame_receiver_top.sv */
`timescale 1ns / 1ps

// A frame result is built when its last CRC byte advances from the input register,
// and is loaded into the output register; other bytes produce no beat.
// Throughput: one byte per cycle, set by the combinational CRC byte update; the
// input stalls only while a result waits in the output register with m_axis_tready low.
// Reset (rst_n low, asynchronous): frame position 0, CRC 0xFFFF, all pending
// and held values 0, both stages empty.
module crc16_command_frame_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [0] crc_ok, [3:1] digital_out,
                                        // [15:4] duty_a, [27:16] duty_b, [31:28] zero
);
    import crc_cfr_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_mode_reg;

    logic [2:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  pend_bits_reg, pend_bits_next;
    logic [15:0] raw_a_reg, raw_a_next;
    logic [15:0] raw_b_reg, raw_b_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [2:0]  held_bits_reg, held_bits_next;
    logic [11:0] held_duty_a_reg, held_duty_a_next;
    logic [11:0] held_duty_b_reg, held_duty_b_next;

    logic        out_valid_reg;
    result_t     out_reg;
    result_t     out_next;

    logic        advance;
    logic        result_load;
    logic        crc_match;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign crc_match     = ({in_byte_reg, crc_lo_reg} == crc_reg);
    assign result_load   = advance && !in_mode_reg && (pos_reg == POS_CRC_HI);

    always_comb
    begin
        pos_next         = pos_reg;
        crc_next         = crc_reg;
        pend_bits_next   = pend_bits_reg;
        raw_a_next       = raw_a_reg;
        raw_b_next       = raw_b_reg;
        crc_lo_next      = crc_lo_reg;
        held_bits_next   = held_bits_reg;
        held_duty_a_next = held_duty_a_reg;
        held_duty_b_next = held_duty_b_reg;
        if (in_mode_reg)
        begin
            pos_next = '0;
            crc_next = CRC_INIT;
        end
        else if (pos_reg == POS_CRC_HI)
        begin
            pos_next = '0;
            crc_next = CRC_INIT;
            if (crc_match)
            begin
                held_bits_next   = pend_bits_reg;
                held_duty_a_next = scale_duty(raw_a_reg);
                held_duty_b_next = scale_duty(raw_b_reg);
            end
        end
        else if (pos_reg == POS_CRC_LO)
        begin
            crc_lo_next = in_byte_reg;
            pos_next    = pos_reg + 3'd1;
        end
        else
        begin
            crc_next = crc_byte(crc_reg, in_byte_reg);
            pos_next = pos_reg + 3'd1;
            case (pos_reg)
                POS_BITS: pend_bits_next = in_byte_reg[2:0];
                POS_A_LO: raw_a_next     = {raw_a_reg[15:8], in_byte_reg};
                POS_A_HI: raw_a_next     = {in_byte_reg, raw_a_reg[7:0]};
                POS_B_LO: raw_b_next     = {raw_b_reg[15:8], in_byte_reg};
                POS_B_HI: raw_b_next     = {in_byte_reg, raw_b_reg[7:0]};
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        out_next.crc_ok      = crc_match;
        out_next.digital_out = held_bits_next;
        out_next.duty_a      = held_duty_a_next;
        out_next.duty_b      = held_duty_b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= '0;
            in_mode_reg  <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
            in_byte_reg  <= s_axis_tdata;
            in_mode_reg  <= s_axis_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            crc_reg         <= CRC_INIT;
            pend_bits_reg   <= '0;
            raw_a_reg       <= '0;
            raw_b_reg       <= '0;
            crc_lo_reg      <= '0;
            held_bits_reg   <= '0;
            held_duty_a_reg <= '0;
            held_duty_b_reg <= '0;
        end
        else if (advance)
        begin
            pos_reg         <= pos_next;
            crc_reg         <= crc_next;
            pend_bits_reg   <= pend_bits_next;
            raw_a_reg       <= raw_a_next;
            raw_b_reg       <= raw_b_next;
            crc_lo_reg      <= crc_lo_next;
            held_bits_reg   <= held_bits_next;
            held_duty_a_reg <= held_duty_a_next;
            held_duty_b_reg <= held_duty_b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the beat until taken
    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> (pos_reg == 3'd0 && crc_reg == CRC_INIT))
        else $error("frame state not restarted after result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_load && !crc_match) |=>
            (held_bits_reg == $past(held_bits_reg) &&
             held_duty_a_reg == $past(held_duty_a_reg) &&
             held_duty_b_reg == $past(held_duty_b_reg)))
        else $error("held values changed on CRC mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without output backpressure");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_mode_reg) |=> (pos_reg == 3'd0 && !$rose(m_axis_tvalid)))
        else $error("abort produced a result or kept frame position");

endmodule

/* tb/crc16_command_frame_receiver_top_tb.sv */
`timescale 1ns / 1ps

module crc16_command_frame_receiver_top_tb;

    import crc_cfr_pkg::*;

    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_ABORT = 1'b1;
    localparam int   RANDOM_ITEMS = 1550;
    localparam int   DIR_ROWS = 27;

    typedef enum logic [2:0] {
        ROW_DATA,
        ROW_CRC_LO,
        ROW_CRC_BAD_LO,
        ROW_CRC_HI,
        ROW_ABORT
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  value;
        bit          has_exp;
        result_t     exp;
    } dir_row_t;

    typedef struct {
        logic [7:0]  data;
        logic        mode;
        bit          has_exp;
        result_t     exp;
    } rx_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    dir_row_t    dir_table [0:DIR_ROWS-1];
    rx_item_t    rx_items[$];
    result_t     expected_frames[$];
    bit          stim_ready;
    bit          hold_off;
    int          n_directed;
    int          in_count;
    int          shown;
    int          err_count;

    logic [2:0]  frame_pos;
    logic [15:0] crc_acc;
    logic [2:0]  pend_bits;
    logic [15:0] pend_raw_a;
    logic [15:0] pend_raw_b;
    logic [7:0]  crc_lo_seen;
    logic [2:0]  hold_bits;
    logic [11:0] hold_duty_a;
    logic [11:0] hold_duty_b;

    crc16_command_frame_receiver_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [11:0] duty_from_raw(input logic [15:0] raw);
        int unsigned d;
        d = (int'(raw) * 4095) / 1024;
        return (d > 4095) ? DUTY_MAX : d[11:0];
    endfunction

    function automatic result_t frame_result(input logic ok, input logic [2:0] bits,
                                             input logic [11:0] a, input logic [11:0] b);
        result_t r;
        r.crc_ok      = ok;
        r.digital_out = bits;
        r.duty_a      = a;
        r.duty_b      = b;
        return r;
    endfunction

    function automatic logic [15:0] pick_raw();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            return 16'($urandom_range(0, 1100));
        end
        else if (sel < 60)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h0000;
                1:       return 16'hFFFF;
                2:       return 16'd1024;
                default: return 16'd1025;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic int idle_phase();
        int p;
        if (in_count < n_directed)
        begin
            return 0;
        end
        p = ((in_count - n_directed) * 4) / (rx_items.size() - n_directed);
        return (p > 3) ? 3 : p;
    endfunction

    function automatic int sender_idle_pct();
        case (idle_phase())
            1:       return 86;
            3:       return 37;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_phase())
            2:       return 86;
            3:       return 37;
            default: return 0;
        endcase
    endfunction

    task automatic push_item(input logic [7:0] data, input logic mode);
        rx_item_t it;
        it.data    = data;
        it.mode    = mode;
        it.has_exp = 1'b0;
        it.exp     = '0;
        rx_items.push_back(it);
    endtask

    task automatic push_random_frame(input bit corrupt);
        logic [7:0]  fb [0:7];
        logic [15:0] acc;
        logic [15:0] raw_a;
        logic [15:0] raw_b;
        raw_a = pick_raw();
        raw_b = pick_raw();
        fb[0] = 8'($urandom);
        fb[1] = 8'($urandom);
        fb[2] = raw_a[7:0];
        fb[3] = raw_a[15:8];
        fb[4] = raw_b[7:0];
        fb[5] = raw_b[15:8];
        acc = CRC_INIT;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            acc = modbus_crc_step(acc, fb[i]);
        end
        fb[6] = acc[7:0];
        fb[7] = acc[15:8];
        if (corrupt)
        begin
            fb[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
        end
        for (int i = 0; i < 8; i++)
        begin
            push_item(fb[i], MODE_DATA);
        end
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic m,
                                output bit produced, output result_t r);
        logic [15:0] recv;
        produced = 1'b0;
        r = '0;
        if (m == MODE_ABORT)
        begin
            frame_pos = 3'd0;
            crc_acc   = CRC_INIT;
        end
        else if (frame_pos < POS_CRC_LO)
        begin
            crc_acc = modbus_crc_step(crc_acc, b);
            case (frame_pos)
                POS_BITS: pend_bits        = b[2:0];
                POS_A_LO: pend_raw_a[7:0]  = b;
                POS_A_HI: pend_raw_a[15:8] = b;
                POS_B_LO: pend_raw_b[7:0]  = b;
                POS_B_HI: pend_raw_b[15:8] = b;
                default: ;
            endcase
            frame_pos = frame_pos + 3'd1;
        end
        else if (frame_pos == POS_CRC_LO)
        begin
            crc_lo_seen = b;
            frame_pos = frame_pos + 3'd1;
        end
        else
        begin
            recv = {b, crc_lo_seen};
            if (recv == crc_acc)
            begin
                hold_bits   = pend_bits;
                hold_duty_a = duty_from_raw(pend_raw_a);
                hold_duty_b = duty_from_raw(pend_raw_b);
            end
            r = frame_result(recv == crc_acc, hold_bits, hold_duty_a, hold_duty_b);
            produced = 1'b1;
            frame_pos = 3'd0;
            crc_acc   = CRC_INIT;
        end
    endtask

    task automatic flag_mismatch(input string what, input result_t want, input logic [31:0] got);
        err_count++;
        if (err_count <= 10)
        begin
            $display("%0t: %s: expected ok=%0d bits=%0d a=%0d b=%0d, got tdata=%08h",
                     $realtime, what, want.crc_ok, want.digital_out, want.duty_a,
                     want.duty_b, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [15:0] acc;
        rx_item_t    it;
        int          sel;
        int          k;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = MODE_DATA;
        m_axis_tready = 1'b0;
        stim_ready    = 1'b0;
        hold_off      = 1'b0;
        in_count      = 0;
        shown         = -1;
        err_count     = 0;
        frame_pos     = 3'd0;
        crc_acc       = CRC_INIT;
        pend_bits     = '0;
        pend_raw_a    = '0;
        pend_raw_b    = '0;
        crc_lo_seen   = '0;
        hold_bits     = '0;
        hold_duty_a   = '0;
        hold_duty_b   = '0;

        dir_table = '{
            '{ROW_DATA,       8'h00, 1'b0, '0},
            '{ROW_DATA,       8'h00, 1'b0, '0},
            '{ROW_DATA,       8'h00, 1'b0, '0},
            '{ROW_DATA,       8'h00, 1'b0, '0},
            '{ROW_DATA,       8'h00, 1'b0, '0},
            '{ROW_DATA,       8'h00, 1'b0, '0},
            '{ROW_CRC_BAD_LO, 8'h00, 1'b0, '0},
            '{ROW_CRC_HI,     8'h00, 1'b1, frame_result(1'b0, 3'd0, 12'd0, 12'd0)},
            '{ROW_ABORT,      8'hFF, 1'b0, '0},
            '{ROW_DATA,       8'hFF, 1'b0, '0},
            '{ROW_DATA,       8'hFF, 1'b0, '0},
            '{ROW_DATA,       8'hFF, 1'b0, '0},
            '{ROW_DATA,       8'hFF, 1'b0, '0},
            '{ROW_DATA,       8'h00, 1'b0, '0},
            '{ROW_DATA,       8'h00, 1'b0, '0},
            '{ROW_CRC_LO,     8'h00, 1'b0, '0},
            '{ROW_CRC_HI,     8'h00, 1'b1, frame_result(1'b1, 3'd7, 12'd4095, 12'd0)},
            '{ROW_DATA,       8'h12, 1'b0, '0},
            '{ROW_ABORT,      8'h00, 1'b0, '0},
            '{ROW_DATA,       8'h00, 1'b0, '0},
            '{ROW_DATA,       8'h00, 1'b0, '0},
            '{ROW_DATA,       8'h00, 1'b0, '0},
            '{ROW_DATA,       8'h04, 1'b0, '0},
            '{ROW_DATA,       8'hFF, 1'b0, '0},
            '{ROW_DATA,       8'h03, 1'b0, '0},
            '{ROW_CRC_LO,     8'h00, 1'b0, '0},
            '{ROW_CRC_HI,     8'h00, 1'b0, '0}
        };

        acc = CRC_INIT;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            it.mode    = MODE_DATA;
            it.has_exp = dir_table[i].has_exp;
            it.exp     = dir_table[i].exp;
            case (dir_table[i].kind)
                ROW_DATA:
                begin
                    it.data = dir_table[i].value;
                    acc = modbus_crc_step(acc, it.data);
                end
                ROW_CRC_LO:     it.data = acc[7:0];
                ROW_CRC_BAD_LO: it.data = ~acc[7:0];
                ROW_CRC_HI:
                begin
                    it.data = acc[15:8];
                    acc = CRC_INIT;
                end
                default:
                begin
                    it.data = dir_table[i].value;
                    it.mode = MODE_ABORT;
                    acc = CRC_INIT;
                end
            endcase
            rx_items.push_back(it);
        end
        n_directed = rx_items.size();

        while (rx_items.size() < n_directed + RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                push_random_frame(1'b0);
            end
            else if (sel < 82)
            begin
                push_random_frame(1'b1);
            end
            else if (sel < 92)
            begin
                k = $urandom_range(0, 7);
                repeat (k) push_item(8'($urandom), MODE_DATA);
                push_item(8'($urandom), MODE_ABORT);
            end
            else
            begin
                k = $urandom_range(1, 12);
                repeat (k)
                begin
                    push_item(8'($urandom), ($urandom_range(0, 3) == 0) ? MODE_ABORT : MODE_DATA);
                end
                push_item(8'($urandom), MODE_ABORT);
            end
        end
        stim_ready = 1'b1;

        wait (rst_n);
        wait (in_count == rx_items.size());
        while (expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hold off the output long enough to back up the input
    initial
    begin
        wait (stim_ready && in_count >= n_directed + 150);
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n && stim_ready)
        begin
            if (!(s_axis_tvalid && in_count == shown))
            begin
                if (in_count >= rx_items.size() || $urandom_range(0, 99) < sender_idle_pct())
                begin
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= rx_items[in_count].data;
                    s_axis_tuser  <= rx_items[in_count].mode;
                    shown = in_count;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= receiver_stall_pct());
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        bit      produced;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[27:0]);
                if (expected_frames.size() == 0)
                begin
                    flag_mismatch("result with none expected", '0, m_axis_tdata);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (got.crc_ok != want.crc_ok || got.digital_out != want.digital_out
                        || got.duty_a != want.duty_a || got.duty_b != want.duty_b
                        || m_axis_tdata[31:28] != 4'd0)
                    begin
                        flag_mismatch("frame result mismatch", want, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_beat(s_axis_tdata, s_axis_tuser, produced, want);
                if (produced)
                begin
                    expected_frames.push_back(rx_items[in_count].has_exp ?
                                              rx_items[in_count].exp : want);
                end
                in_count++;
            end
        end
    end

endmodule
